// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge, off while reset is asserted
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// types, codes and level conversion shared by the ppm frame decoder
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_MIN  = 2'd0;
    localparam logic [1:0] CFG_SYNC_MAX  = 2'd1;
    localparam logic [1:0] CFG_PULSE_MIN = 2'd2;
    localparam logic [1:0] CFG_PULSE_MAX = 2'd3;

    localparam logic [15:0] SYNC_MIN_RST  = 16'd4000;
    localparam logic [15:0] SYNC_MAX_RST  = 16'd22500;
    localparam logic [15:0] PULSE_MIN_RST = 16'd800;
    localparam logic [15:0] PULSE_MAX_RST = 16'd2200;

    // event codes
    localparam logic [1:0] EV_SYNC    = 2'd0;
    localparam logic [1:0] EV_CHANNEL = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;

    // level = (width - 800) / 44, saturated at 31
    localparam logic [15:0] LEVEL_OFFSET   = 16'd800;
    localparam int          LEVEL_STEP     = 44;
    localparam int          LEVEL_MAX      = 31;
    localparam logic [15:0] LEVEL_SAT_SPAN = 16'(LEVEL_STEP * (LEVEL_MAX + 1));
    localparam int          LEVEL_SHIFT    = 16;
    // ceil(2^16 / 44), exact for spans below 2730
    localparam logic [10:0] LEVEL_RECIP    =
        11'(((1 << LEVEL_SHIFT) + LEVEL_STEP - 1) / LEVEL_STEP);

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [15:0] len;
        logic [15:0] frame;
    } pfd_entry_t;

    function automatic logic [4:0] level_of(input logic [15:0] width);
        logic [15:0] span;
        logic [21:0] prod;
        span = width - LEVEL_OFFSET;
        prod = 22'(span[10:0]) * 22'(LEVEL_RECIP);
        if (width < LEVEL_OFFSET)
            return 5'd0;
        else if (span >= LEVEL_SAT_SPAN)
            return 5'(LEVEL_MAX);
        else
            return prod[20:16];
    endfunction

endpackage

// ===== sv/pfd_front.sv =====
// ----------------------------------------------------------------------------
// pfd_front
// pulse measurement, classification and frame state
// ----------------------------------------------------------------------------
module pfd_front
    import pfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] capture_time,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        push,
    output pfd_entry_t  push_entry
);

    localparam int CW = $clog2(NUM_CHANNELS + 1);

    logic [15:0]   sync_min_reg;
    logic [15:0]   sync_max_reg;
    logic [15:0]   pulse_min_reg;
    logic [15:0]   pulse_max_reg;
    logic [15:0]   last_capture_reg;
    logic [15:0]   sync_capture_reg;
    logic          sync_valid_reg;
    logic [CW-1:0] chan_cnt_reg;

    logic [15:0] len;
    logic        is_sync;
    logic        is_chan;

    assign push = in_valid && !in_stall;
    assign len  = capture_time - last_capture_reg;

    assign is_sync = (len > sync_min_reg) && (len < sync_max_reg);
    assign is_chan = sync_valid_reg && (len > pulse_min_reg) && (len < pulse_max_reg)
                     && (chan_cnt_reg < CW'(NUM_CHANNELS));

    always_comb
    begin
        push_entry.len   = len;
        push_entry.idx   = 3'd0;
        push_entry.frame = 16'd0;
        if (is_sync)
        begin
            push_entry.kind  = EV_SYNC;
            push_entry.frame = capture_time - sync_capture_reg;
        end
        else if (is_chan)
        begin
            push_entry.kind = EV_CHANNEL;
            push_entry.idx  = 3'(chan_cnt_reg);
        end
        else
        begin
            push_entry.kind = EV_REJECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min_reg     <= SYNC_MIN_RST;
            sync_max_reg     <= SYNC_MAX_RST;
            pulse_min_reg    <= PULSE_MIN_RST;
            pulse_max_reg    <= PULSE_MAX_RST;
            last_capture_reg <= '0;
            sync_capture_reg <= '0;
            sync_valid_reg   <= 1'b0;
            chan_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SYNC_MIN:  sync_min_reg  <= cfg_data;
                    CFG_SYNC_MAX:  sync_max_reg  <= cfg_data;
                    CFG_PULSE_MIN: pulse_min_reg <= cfg_data;
                    CFG_PULSE_MAX: pulse_max_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (push)
            begin
                last_capture_reg <= capture_time;
                if (is_sync)
                begin
                    sync_capture_reg <= capture_time;
                    sync_valid_reg   <= 1'b1;
                    chan_cnt_reg     <= '0;
                end
                else if (is_chan)
                begin
                    chan_cnt_reg <= chan_cnt_reg + 1'b1;
                end
                else
                begin
                    sync_valid_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== sv/pfd_queue.sv =====
// ----------------------------------------------------------------------------
// pfd_queue
// short fifo of classified events between front and back
// ----------------------------------------------------------------------------
module pfd_queue
    import pfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pfd_entry_t push_entry,
    input  logic       pop,
    output pfd_entry_t head,
    output logic       empty,
    output logic       full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pfd_entry_t    slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/pfd_back.sv =====
// ----------------------------------------------------------------------------
// pfd_back
// level conversion and registered result output
// ----------------------------------------------------------------------------
module pfd_back
    import pfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pfd_entry_t  head,
    input  logic        empty,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [1:0]  event_kind,
    output logic [2:0]  channel_index,
    output logic [15:0] pulse_width,
    output logic [4:0]  level_code,
    output logic [15:0] frame_length
);

    logic        out_valid_reg;
    logic [4:0]  level_next;

    assign pop       = !empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign level_next = (head.kind == EV_CHANNEL) ? level_of(head.len) : 5'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_kind    <= head.kind;
            channel_index <= head.idx;
            pulse_width   <= head.len;
            level_code    <= level_next;
            frame_length  <= head.frame;
        end
    end

endmodule

// ===== sv/ppm_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder_unit
// path: a capture transaction is registered in a queue slot, then in the output register
// throughput: one capture per cycle while the queue is not full, as the front classifies combinationally
// input stalls only when the queue (two entries by default) is full behind a stalled output
// reset: thresholds to defaults, sync lost, channel count and timestamps zero
// ----------------------------------------------------------------------------
module ppm_frame_decoder_unit
    import pfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // capture channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] capture_time,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [2:0]  channel_index,
    output logic [15:0] pulse_width,
    output logic [4:0]  level_code,
    output logic [15:0] frame_length,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // front side: measures the pulse against the previous capture and
    // decides sync / channel / reject, updating frame state right away so
    // the next capture can follow in the very next cycle
    logic       push;
    pfd_entry_t push_entry;

    // queue status and head entry seen by the back side
    logic       pop;
    logic       q_empty;
    logic       q_full;
    pfd_entry_t q_head;

    // registers are writable at any time; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // capture stalls only when the queue cannot take another transaction
    assign in_stall = q_full;

    pfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .capture_time (capture_time),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .push_entry   (push_entry)
    );

    // decouples classification from output backpressure
    pfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // back side: level conversion (reciprocal multiply) into the output register
    pfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .empty         (q_empty),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .event_kind    (event_kind),
        .channel_index (channel_index),
        .pulse_width   (pulse_width),
        .level_code    (level_code),
        .frame_length  (frame_length)
    );

endmodule

// ===== sv/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_checker
// port-level checks on the ppm frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfd_checker
    import pfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_kind,
    input logic [2:0]  channel_index,
    input logic [15:0] pulse_width,
    input logic [4:0]  level_code,
    input logic [15:0] frame_length
);

    // a held result keeps its kind, pulse width and frame length
    `PFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(pulse_width) && $stable(frame_length), "stalled result changed")

    // input backs up only behind a waiting result
    `PFD_ASSERT(a_stall_cause, clk, rst_n, !in_stall || out_valid, "input stalled with no result pending")

    // slot and level only carried by channel events
    `PFD_ASSERT(a_chan_fields, clk, rst_n, !out_valid || event_kind == EV_CHANNEL || (channel_index == 3'd0 && level_code == 5'd0), "channel fields set on non-channel event")

    // frame length only carried by sync events
    `PFD_ASSERT(a_frame_field, clk, rst_n, !out_valid || event_kind == EV_SYNC || frame_length == 16'd0, "frame length set on non-sync event")

endmodule

bind ppm_frame_decoder_unit pfd_checker u_pfd_checker (.*);
